// ===== rtl/pac_pkg.sv =====
package pac_pkg;

   // Port width of one coordinate field
   localparam int COORD_W = 16;

   // Running sum widths; sums wrap two's complement at these widths
   localparam int AREA_W = 40;
   localparam int MOM_W  = 56;

   // Divisor width: three times a 40-bit signed twice-area
   localparam int DEN_W  = 42;

   // Status of the shared divider as seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/pac_div.sv =====
// Radix-2 restoring divider for the centroid.
// Signed numerator over signed nonzero divisor. The quotient is truncated
// toward zero and saturated to the signed COORD_BITS range.
// One quotient bit per cycle; result is valid while status.done is high.
module pac_div
   import pac_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [MOM_W-1:0]      num,
   input  logic signed [DEN_W-1:0]      den,
   output div_status_type               status,
   output logic signed [COORD_BITS-1:0] quo
);

   localparam int CNT_W = $clog2(MOM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOM_W - 1);
   localparam logic [MOM_W-1:0] SAT_HI = MOM_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
   localparam logic [MOM_W-1:0] SAT_LO_MAG = SAT_HI + MOM_W'(1);

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      SAT
   } div_state_type;

   div_state_type           state_ff;
   logic                    done_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [DEN_W-1:0]        rem_ff;
   logic [MOM_W-1:0]        quo_ff;
   logic [DEN_W-1:0]        den_mag_ff;
   logic                    neg_ff;
   logic signed [COORD_BITS-1:0] result_ff;

   logic [DEN_W:0]          shifted;
   logic [DEN_W+1:0]        trial;
   logic [MOM_W-1:0]        sat_val;

   // One restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[MOM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_mag_ff};
   end

   // Saturate the magnitude, then apply the sign
   always_comb begin
      if (!neg_ff) begin
         sat_val = (quo_ff > SAT_HI) ? SAT_HI : quo_ff;
      end else begin
         sat_val = (quo_ff > SAT_LO_MAG) ? (MOM_W'(0) - SAT_LO_MAG) : (MOM_W'(0) - quo_ff);
      end
   end

   // Sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= RUN;
               end
            end
            RUN: begin
               if (cnt_ff == CNT_LAST) begin
                  state_ff <= SAT;
               end
            end
            SAT: begin
               state_ff <= IDLE;
               done_ff  <= 1'b1;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cnt_ff     <= '0;
               rem_ff     <= '0;
               quo_ff     <= num[MOM_W-1] ? (MOM_W'(0) - MOM_W'(num)) : MOM_W'(num);
               den_mag_ff <= den[DEN_W-1] ? (DEN_W'(0) - DEN_W'(den)) : DEN_W'(den);
               neg_ff     <= num[MOM_W-1] ^ den[DEN_W-1];
            end
         end
         RUN: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (!trial[DEN_W+1]) begin
               rem_ff <= trial[DEN_W-1:0];
               quo_ff <= {quo_ff[MOM_W-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[DEN_W-1:0];
               quo_ff <= {quo_ff[MOM_W-2:0], 1'b0};
            end
         end
         SAT: begin
            result_ff <= sat_val[COORD_BITS-1:0];
         end
         default: begin
         end
      endcase
   end

   assign status.busy = (state_ff != IDLE);
   assign status.done = done_ff;
   assign quo         = result_ff;

   // A start only reaches an idle divider
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == IDLE))
      else $error("divider started while busy");

   // Done is a single-cycle pulse after the saturation step
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   // A run always covers the full quotient width before saturation
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SAT) |-> ($past(cnt_ff) == CNT_LAST))
      else $error("divider left run early");

endmodule

// ===== rtl/polygon_area_centroid_core.sv =====
// Shoelace polygon area and centroid. Vertices arrive one per transfer on
// req_ as signed Q7.8 x and y; req_last_vertex closes the polygon back to
// its first vertex, and one result transfer on rsp_ then carries twice the
// signed area (16 fraction bits) and the centroid (Q7.8, truncated toward
// zero and saturated). With fewer than three vertices or a zero area the
// centroid is 0 and rsp_centroid_valid is low. Each vertex after the first
// of a polygon takes six sequencer steps around the shared 17x33
// multiplier per edge. The last vertex adds the closing edge back to the
// first and, when the centroid is valid, two passes of the
// one-bit-per-cycle divider over 56 quotient bits. The result then waits
// for the output register to free up.
// req_stall is high for the whole time a vertex is being worked on; a
// finished result waits in the output register while the next polygon
// streams in.
module polygon_area_centroid_core
   import pac_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [COORD_W-1:0]       req_vert_x,
   input  logic [COORD_W-1:0]       req_vert_y,
   input  logic                     req_last_vertex,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [AREA_W-1:0]        rsp_twice_area,
   output logic [COORD_W-1:0]       rsp_centroid_x,
   output logic [COORD_W-1:0]       rsp_centroid_y,
   output logic                     rsp_centroid_valid
);

   localparam int OPA_W  = COORD_BITS + 1;
   localparam int CRS_W  = 2 * COORD_BITS;
   localparam int OPB_W  = 2 * COORD_BITS + 1;
   localparam int PROD_W = OPA_W + OPB_W;

   typedef enum logic [3:0] {
      IDLE,
      MUL_PC,
      MUL_CP,
      DIFF,
      MOM_X,
      MOM_Y,
      ACC_Y,
      FINISH,
      DIV_X,
      DIV_Y,
      RESULT
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic          closing_ff;
   logic          div_start_ff;
   logic          rsp_valid_ff;
   logic [AREA_W-1:0]  rsp_area_ff;
   logic [COORD_W-1:0] rsp_cx_ff;
   logic [COORD_W-1:0] rsp_cy_ff;
   logic               rsp_cvalid_ff;

   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;
   logic signed [COORD_BITS-1:0] in_x_ff, in_y_ff;
   logic                         in_last_ff;
   logic [1:0]                   vertex_seen_ff;
   logic [AREA_W-1:0]            area_sum_ff;
   logic [MOM_W-1:0]             mom_x_sum_ff, mom_y_sum_ff;

   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [CRS_W-1:0]      cross_ff;
   logic signed [OPB_W-1:0]      a_ff;
   logic signed [OPA_W-1:0]      sx_ff, sy_ff;
   logic signed [DEN_W-1:0]      den_ff;
   logic                         cvalid_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;

   logic                         req_accept;
   logic                         rsp_xfer;
   logic                         out_free;
   logic signed [COORD_BITS-1:0] vx, vy;
   logic signed [COORD_BITS-1:0] p_x, p_y, c_x, c_y;
   logic signed [OPA_W-1:0]      mul_a;
   logic signed [OPB_W-1:0]      mul_b;
   logic signed [AREA_W-1:0]     area_s;
   logic                         fin_valid;
   logic signed [MOM_W-1:0]      div_num;
   div_status_type               div_stat;
   logic signed [COORD_BITS-1:0] div_quo;

   assign req_stall  = reset | (state_ff != IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_xfer   = rsp_valid_ff & ~rsp_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // Coordinates are taken from the low COORD_BITS bits
   assign vx = req_vert_x[COORD_BITS-1:0];
   assign vy = req_vert_y[COORD_BITS-1:0];

   // Edge endpoints: previous to current, or current back to first
   assign p_x = closing_ff ? in_x_ff : prev_x_ff;
   assign p_y = closing_ff ? in_y_ff : prev_y_ff;
   assign c_x = closing_ff ? first_x_ff : in_x_ff;
   assign c_y = closing_ff ? first_y_ff : in_y_ff;

   // Operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         MUL_PC: begin
            mul_a = OPA_W'(p_x);
            mul_b = OPB_W'(c_y);
         end
         MUL_CP: begin
            mul_a = OPA_W'(c_x);
            mul_b = OPB_W'(p_y);
         end
         MOM_X: begin
            mul_a = sx_ff;
            mul_b = a_ff;
         end
         MOM_Y: begin
            mul_a = sy_ff;
            mul_b = a_ff;
         end
         default: begin
         end
      endcase
   end

   assign area_s    = area_sum_ff;
   assign fin_valid = (vertex_seen_ff == 2'd3) && (area_sum_ff != '0);
   assign div_num   = (state_ff == DIV_X) ? mom_x_sum_ff : mom_y_sum_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_accept) begin
               if (vertex_seen_ff == 2'd0) begin
                  state_in = req_last_vertex ? FINISH : IDLE;
               end else begin
                  state_in = MUL_PC;
               end
            end
         end
         MUL_PC: state_in = MUL_CP;
         MUL_CP: state_in = DIFF;
         DIFF:   state_in = MOM_X;
         MOM_X:  state_in = MOM_Y;
         MOM_Y:  state_in = ACC_Y;
         ACC_Y: begin
            if (closing_ff) begin
               state_in = FINISH;
            end else begin
               state_in = in_last_ff ? MUL_PC : IDLE;
            end
         end
         FINISH: state_in = fin_valid ? DIV_X : RESULT;
         DIV_X: begin
            if (div_stat.done) begin
               state_in = DIV_Y;
            end
         end
         DIV_Y: begin
            if (div_stat.done) begin
               state_in = RESULT;
            end
         end
         RESULT: begin
            if (out_free) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // Sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         closing_ff   <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= ((state_ff == FINISH) && fin_valid) ||
                         ((state_ff == DIV_X) && div_stat.done);
         if (state_ff == ACC_Y && !closing_ff && in_last_ff) begin
            closing_ff <= 1'b1;
         end
         if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == RESULT && out_free) begin
            closing_ff    <= 1'b0;
            rsp_valid_ff  <= 1'b1;
            rsp_area_ff   <= (vertex_seen_ff == 2'd3) ? area_sum_ff : '0;
            rsp_cx_ff     <= COORD_W'(cx_ff);
            rsp_cy_ff     <= COORD_W'(cy_ff);
            rsp_cvalid_ff <= cvalid_ff;
         end
      end
   end

   // Polygon state: first and previous vertex, count and running sums
   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff     <= '0;
         first_y_ff     <= '0;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         vertex_seen_ff <= 2'd0;
         area_sum_ff    <= '0;
         mom_x_sum_ff   <= '0;
         mom_y_sum_ff   <= '0;
      end else begin
         if (req_accept) begin
            if (vertex_seen_ff == 2'd0) begin
               first_x_ff <= vx;
               first_y_ff <= vy;
               prev_x_ff  <= vx;
               prev_y_ff  <= vy;
            end
            if (vertex_seen_ff != 2'd3) begin
               vertex_seen_ff <= vertex_seen_ff + 2'd1;
            end
         end
         if (state_ff == MOM_X) begin
            area_sum_ff <= area_sum_ff + AREA_W'(a_ff);
         end
         if (state_ff == MOM_Y) begin
            mom_x_sum_ff <= mom_x_sum_ff + MOM_W'(prod_ff);
         end
         if (state_ff == ACC_Y) begin
            mom_y_sum_ff <= mom_y_sum_ff + MOM_W'(prod_ff);
            if (!closing_ff) begin
               prev_x_ff <= in_x_ff;
               prev_y_ff <= in_y_ff;
            end
         end
         if (state_ff == RESULT && out_free) begin
            first_x_ff     <= '0;
            first_y_ff     <= '0;
            prev_x_ff      <= '0;
            prev_y_ff      <= '0;
            vertex_seen_ff <= 2'd0;
            area_sum_ff    <= '0;
            mom_x_sum_ff   <= '0;
            mom_y_sum_ff   <= '0;
         end
      end
   end

   // Working registers: input vertex, multiplier, cross term, edge sums, divisor, centroid
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_x_ff    <= vx;
         in_y_ff    <= vy;
         in_last_ff <= req_last_vertex;
      end
      prod_ff <= mul_a * mul_b;
      if (state_ff == MUL_CP) begin
         cross_ff <= prod_ff[CRS_W-1:0];
      end
      if (state_ff == DIFF) begin
         a_ff  <= OPB_W'(cross_ff) - OPB_W'($signed(prod_ff[CRS_W-1:0]));
         sx_ff <= OPA_W'(c_x) + OPA_W'(p_x);
         sy_ff <= OPA_W'(c_y) + OPA_W'(p_y);
      end
      if (state_ff == FINISH) begin
         cvalid_ff <= fin_valid;
         den_ff    <= DEN_W'(area_s) + (DEN_W'(area_s) <<< 1);
         cx_ff     <= '0;
         cy_ff     <= '0;
      end
      if (state_ff == DIV_X && div_stat.done) begin
         cx_ff <= div_quo;
      end
      if (state_ff == DIV_Y && div_stat.done) begin
         cy_ff <= div_quo;
      end
   end

   pac_div #(
      .COORD_BITS(COORD_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num),
      .den   (den_ff),
      .status(div_stat),
      .quo   (div_quo)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_twice_area     = rsp_area_ff;
   assign rsp_centroid_x     = rsp_cx_ff;
   assign rsp_centroid_y     = rsp_cy_ff;
   assign rsp_centroid_valid = rsp_cvalid_ff;

   // Divider is only kicked while the sequencer waits on it
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> (state_ff == DIV_X || state_ff == DIV_Y))
      else $error("divider start outside a division step");

   // Divider only runs during the two division steps
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == DIV_X || state_ff == DIV_Y))
      else $error("divider busy outside a division step");

   // An invalid centroid goes out as zero, a valid one with nonzero area
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cvalid_ff ? (rsp_area_ff != '0)
                                      : (rsp_cx_ff == '0 && rsp_cy_ff == '0)))
      else $error("centroid and valid flag disagree");

   // Delivering a result leaves a clean polygon state behind
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RESULT && out_free) |=>
         (vertex_seen_ff == 2'd0 && area_sum_ff == '0 && !closing_ff))
      else $error("polygon state not cleared after result");

endmodule
